>>> sv/source_text_lexer_macros.svh
// ----------------------------------------------------------------------------
// source_text_lexer_macros
// assertion shorthands for the lexer, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_LEXER_MACROS_SVH
`define SOURCE_TEXT_LEXER_MACROS_SVH

// same-cycle implication
`define STL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// shared types, token kinds and character tables of the source text lexer
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int TextBytesDef = 8;
  localparam int ResDepth     = 4;
  localparam int ResPtrW      = $clog2(ResDepth);
  localparam int ResCntW      = $clog2(ResDepth + 1);
  localparam int OutDataW     = 112;
  localparam int KwCount      = 10;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeIdent  = 2'd1,
    ModeNumber = 2'd2,
    ModeError  = 2'd3
  } mode_e;

  localparam logic [4:0] KindId  = 5'd0;
  localparam logic [4:0] KindNum = 5'd1;
  localparam logic [4:0] KindP0  = 5'd2;
  localparam logic [4:0] KindKw0 = 5'd16;
  localparam logic [4:0] KindErr = 5'd26;

  localparam logic [7:0] ChEot   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUnder = 8'h5F;

  // keywords packed with the first byte in the low bits
  localparam logic [31:0] KwText [KwCount] = '{
    32'h00646E61, 32'h66696C65, 32'h65736C65, 32'h00706D63, 32'h00006E66,
    32'h00726F66, 32'h00006669, 32'h0000726F, 32'h00746572, 32'h00006F74
  };
  localparam logic [7:0] KwLen [KwCount] = '{
    8'd3, 8'd4, 8'd4, 8'd3, 8'd2, 8'd3, 8'd2, 8'd2, 8'd3, 8'd2
  };

  // one result word, kind in the low bits
  typedef struct packed {
    logic [15:0] column;
    logic [15:0] line;
    logic        overflow;
    logic [7:0]  length;
    logic [63:0] text;
    logic [4:0]  kind;
  } res_t;

  // punctuation kind, KindErr when the byte is no punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KindErr;
    case (c)
      "+": k = KindP0 + 5'd0;
      "-": k = KindP0 + 5'd1;
      "/": k = KindP0 + 5'd2;
      "*": k = KindP0 + 5'd3;
      "=": k = KindP0 + 5'd4;
      "!": k = KindP0 + 5'd5;
      ":": k = KindP0 + 5'd6;
      ";": k = KindP0 + 5'd7;
      "(": k = KindP0 + 5'd8;
      ")": k = KindP0 + 5'd9;
      "{": k = KindP0 + 5'd10;
      "}": k = KindP0 + 5'd11;
      "[": k = KindP0 + 5'd12;
      "]": k = KindP0 + 5'd13;
      default: k = KindErr;
    endcase
    return k;
  endfunction

  // keyword kind of a short identifier, KindId when it matches none
  function automatic logic [4:0] kw_kind(input logic [63:0] text, input logic [7:0] len);
    logic [4:0] k;
    k = KindId;
    for (int i = 0; i < KwCount; i++) begin
      if (text == {32'h0, KwText[i]} && len == KwLen[i]) begin
        k = KindKw0 + 5'(i);
      end
    end
    return k;
  endfunction

endpackage

>>> sv/source_text_lexer.sv
// ----------------------------------------------------------------------------
// source_text_lexer
// byte-serial scanner: identifiers, numbers, keywords, punctuation and errors
// ----------------------------------------------------------------------------
// a result word is written into the result queue when the byte that causes it is taken
// throughput: one byte per cycle while the result queue has room for two words;
//   a byte that ends a token and is itself a punctuation or error byte emits
//   two words, absorbed by the four-word result queue
// reset: scanner idle, line and column zero, result queue empty
`include "source_text_lexer_macros.svh"

module source_text_lexer #(
  parameter int TEXT_BYTES = stl_pkg::TextBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // ch
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // text, length, overflow, line, column, zero pad
  output logic [stl_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [4:0]                  m_axis_tuser_o,  // kind
  output logic                        m_axis_tlast_o
);
  import stl_pkg::*;

  localparam int TokW = TEXT_BYTES * 8;

  // scanner state
  mode_e            mode_q, mode_d;
  logic [TokW-1:0]  bytes_q, bytes_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      line_q, line_d;
  logic [15:0]      col_q, col_d;
  logic             start_q, start_d;

  // result queue
  res_t               res_mem_q [ResDepth];
  logic               last_mem_q [ResDepth];
  logic [ResPtrW-1:0] wptr_q, rptr_q;
  logic [ResCntW-1:0] cnt_q;

  logic       accept, pop, eot;
  logic [7:0] c;
  logic       is_alpha, is_digit, is_space, is_punct;
  logic [4:0] p_kind;
  logic       tok_pending, extend;
  logic [15:0] col_next;
  logic       flush_v, single_v;
  logic [1:0] push_n;
  res_t       r0, r1, e0, e1;
  logic       last0;

  assign c        = s_axis_tdata_i;
  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign eot      = (c == ChEot);
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  assign is_digit = (c >= "0" && c <= "9");
  assign is_space = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChNl);
  assign p_kind   = punct_kind(c);
  assign is_punct = (p_kind != KindErr);

  assign tok_pending = (mode_q == ModeIdent) || (mode_q == ModeNumber);
  assign extend = (mode_q == ModeIdent && (is_alpha || is_digit)) ||
                  (mode_q == ModeNumber && is_digit);
  assign col_next = start_q ? 16'd0 : ((col_q != 16'hFFFF) ? col_q + 16'd1 : col_q);

  assign flush_v  = accept && tok_pending && (eot || !extend);
  assign single_v = accept && !eot && (mode_q != ModeError) && !extend &&
                    !is_alpha && !is_digit && !is_space;
  assign push_n   = {1'b0, flush_v} + {1'b0, single_v};

  // result words
  always_comb begin
    r0.kind     = KindNum;
    if (mode_q == ModeIdent) begin
      r0.kind = (len_q > 8'(TEXT_BYTES)) ? KindId : kw_kind(64'(bytes_q), len_q);
    end
    r0.text     = 64'(bytes_q);
    r0.length   = len_q;
    r0.overflow = (len_q > 8'(TEXT_BYTES));
    r0.line     = line_q;
    r0.column   = col_q;

    r1.kind     = is_punct ? p_kind : KindErr;
    r1.text     = {56'h0, c};
    r1.length   = 8'd1;
    r1.overflow = 1'b0;
    r1.line     = line_q;
    r1.column   = col_next;

    e0    = flush_v ? r0 : r1;
    e1    = r1;
    last0 = (push_n == 2'd1);
  end

  // next scanner state
  always_comb begin
    mode_d  = mode_q;
    bytes_d = bytes_q;
    len_d   = len_q;
    line_d  = line_q;
    col_d   = col_q;
    start_d = start_q;
    if (accept) begin
      if (eot) begin
        mode_d  = ModeIdle;
        bytes_d = '0;
        len_d   = 8'd0;
        line_d  = 16'd0;
        col_d   = 16'd0;
        start_d = 1'b1;
      end else if (mode_q != ModeError) begin
        if (extend) begin
          for (int b = 0; b < TEXT_BYTES; b++) begin
            if (len_q == 8'(b)) begin
              bytes_d[b*8 +: 8] = c;
            end
          end
          if (len_q != 8'hFF) begin
            len_d = len_q + 8'd1;
          end
        end else begin
          mode_d  = ModeIdle;
          bytes_d = '0;
          len_d   = 8'd0;
          if (is_alpha || is_digit) begin
            mode_d  = is_alpha ? ModeIdent : ModeNumber;
            bytes_d = TokW'(c);
            len_d   = 8'd1;
          end else if (!is_space && !is_punct) begin
            mode_d = ModeError;
          end
        end
        col_d   = col_next;
        start_d = 1'b0;
        if (c == ChNl) begin
          if (line_q != 16'hFFFF) begin
            line_d = line_q + 16'd1;
          end
          col_d = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      bytes_q <= '0;
      len_q   <= 8'd0;
      line_q  <= 16'd0;
      col_q   <= 16'd0;
      start_q <= 1'b1;
    end else begin
      mode_q  <= mode_d;
      bytes_q <= bytes_d;
      len_q   <= len_d;
      line_q  <= line_d;
      col_q   <= col_d;
      start_q <= start_d;
    end
  end

  // result queue, room for two words is needed to take a byte
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q <= ResCntW'(ResDepth - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {(OutDataW + 5 - $bits(res_t))'(0),
                            res_mem_q[rptr_q][$bits(res_t)-1:5]};
  assign m_axis_tuser_o  = res_mem_q[rptr_q].kind;
  assign m_axis_tlast_o  = last_mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      res_mem_q[wptr_q]  <= e0;
      last_mem_q[wptr_q] <= last0;
    end
    if (push_n == 2'd2) begin
      res_mem_q[wptr_q + ResPtrW'(1)]  <= e1;
      last_mem_q[wptr_q + ResPtrW'(1)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + ResPtrW'(push_n);
      if (pop) begin
        rptr_q <= rptr_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + ResCntW'(push_n) - ResCntW'(pop);
    end
  end

  `STL_ASSERT_NOW(a_err_silent, accept && mode_q == ModeError && !eot, push_n == 2'd0,
                  "word emitted while skipping after an error")
  `STL_ASSERT_NEXT(a_eot_clears, accept && eot,
                   line_q == 16'd0 && col_q == 16'd0 && mode_q == ModeIdle && start_q,
                   "end of text did not reset position")
  `STL_ASSERT_NOW(a_no_overrun, push_n != 2'd0,
                  cnt_q + ResCntW'(push_n) <= ResCntW'(ResDepth), "result queue overrun")
  `STL_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= ResCntW'(ResDepth), "result count out of range")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the source text lexer by streaming byte texts into it and comparing
// every token word against a scoreboard fed by a behavioral scanner in the tb
// ----------------------------------------------------------------------------
module tb;
  import stl_pkg::*;

  localparam int TextBytes = TextBytesDef;
  localparam int HoldCycles = 400;
  localparam int ItemCount = 850;

  typedef struct {
    res_t r;
    bit   last;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    res_t       want;
  } step_t;

  localparam res_t NoRes = '0;
  localparam res_t ErrFF = '{column: 16'd0, line: 16'd0, overflow: 1'b0, length: 8'd1,
                             text: 64'hFF, kind: KindErr};
  localparam res_t Err01 = '{column: 16'd0, line: 16'd0, overflow: 1'b0, length: 8'd1,
                             text: 64'h01, kind: KindErr};

  // directed text: extremes, every token class, flush on newline, eot and error
  localparam step_t DirTab [24] = '{
    '{8'hFF, 1'b1, ErrFF}, '{ChEot, 1'b0, NoRes},
    '{"Z", 1'b0, NoRes}, '{"9", 1'b0, NoRes}, '{ChNl, 1'b0, NoRes},
    '{"0", 1'b0, NoRes}, '{"9", 1'b0, NoRes}, '{"-", 1'b0, NoRes},
    '{ChTab, 1'b0, NoRes}, '{ChCr, 1'b0, NoRes}, '{ChSpace, 1'b0, NoRes},
    '{"e", 1'b0, NoRes}, '{"l", 1'b0, NoRes}, '{"s", 1'b0, NoRes},
    '{"e", 1'b0, NoRes}, '{"]", 1'b0, NoRes}, '{ChUnder, 1'b0, NoRes},
    '{8'h80, 1'b0, NoRes}, '{"x", 1'b0, NoRes}, '{ChEot, 1'b0, NoRes},
    '{"1", 1'b0, NoRes}, '{ChEot, 1'b0, NoRes}, '{8'h01, 1'b1, Err01},
    '{ChEot, 1'b0, NoRes}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tready;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [4:0]   m_tuser;
  logic         m_tlast;

  source_text_lexer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  string kw_names [10] = '{"and", "elif", "else", "cmp", "fn", "for", "if", "or", "ret", "to"};
  string punct_chars = "+-/*=!:;(){}[]";
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_set = "0123456789";
  string space_set = " \t\r\n";

  // scanner state mirrored in the tb
  mode_e       lx_mode;
  logic [63:0] lx_text;
  logic [7:0]  lx_len;
  logic [15:0] lx_line;
  logic [15:0] lx_col;
  bit          lx_fresh;

  token_t token_q [$];

  int  mismatches = 0;
  int  tokens_checked = 0;
  int  err_tokens = 0;
  int  long_tokens = 0;
  int  bytes_sent = 0;
  int  texts = 0;
  bit  idle_en = 1'b1;
  bit  rx_quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChNl;
  endfunction

  function automatic int punct_index(input logic [7:0] c);
    int idx;
    idx = -1;
    for (int i = 0; i < punct_chars.len(); i++) begin
      if (punct_chars[i] == c) idx = i;
    end
    return idx;
  endfunction

  function automatic logic [4:0] keyword_of(input logic [63:0] text, input logic [7:0] len);
    logic [63:0] packed_kw;
    logic [4:0]  k;
    k = KindId;
    if (len <= TextBytes) begin
      for (int i = 0; i < 10; i++) begin
        packed_kw = '0;
        for (int j = 0; j < kw_names[i].len(); j++) packed_kw[8*j +: 8] = kw_names[i][j];
        if (len == kw_names[i].len() && text == packed_kw) k = KindKw0 + 5'(i);
      end
    end
    return k;
  endfunction

  function automatic void post_token(input logic [4:0] kind, input logic [63:0] text,
                                     input logic [7:0] len, input logic [15:0] col);
    token_t t;
    t.r.kind     = kind;
    t.r.text     = text;
    t.r.length   = len;
    t.r.overflow = (len > TextBytes);
    t.r.line     = lx_line;
    t.r.column   = col;
    t.last       = 1'b0;
    token_q.insert(token_q.size(), t);
  endfunction

  function automatic int flush_token();
    if (lx_mode == ModeIdent || lx_mode == ModeNumber) begin
      post_token((lx_mode == ModeIdent) ? keyword_of(lx_text, lx_len) : KindNum,
                 lx_text, lx_len, lx_col);
      lx_text = '0;
      lx_len  = '0;
      lx_mode = ModeIdle;
      return 1;
    end
    return 0;
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (lx_len < TextBytes) lx_text[8*lx_len +: 8] = c;
    if (lx_len != 8'hFF) lx_len = lx_len + 8'd1;
  endfunction

  function automatic void lexer_reset();
    lx_mode  = ModeIdle;
    lx_text  = '0;
    lx_len   = '0;
    lx_line  = '0;
    lx_col   = '0;
    lx_fresh = 1'b1;
  endfunction

  // expected tokens for one accepted source byte
  function automatic void scan_byte(input logic [7:0] c);
    int          n;
    int          p;
    logic [15:0] col;
    n = 0;
    if (c == ChEot) begin
      if (lx_mode != ModeError) n = flush_token();
      lexer_reset();
    end else if (lx_mode != ModeError) begin
      col = lx_fresh ? 16'd0 : ((lx_col != 16'hFFFF) ? lx_col + 16'd1 : 16'hFFFF);
      p = punct_index(c);
      if (lx_mode == ModeIdent && (is_alpha(c) || is_digit(c))) begin
        append_char(c);
      end else if (lx_mode == ModeNumber && is_digit(c)) begin
        append_char(c);
      end else begin
        n = flush_token();
        if (is_alpha(c)) begin
          lx_mode = ModeIdent;
          append_char(c);
        end else if (is_digit(c)) begin
          lx_mode = ModeNumber;
          append_char(c);
        end else if (p >= 0) begin
          post_token(KindP0 + 5'(p), {56'h0, c}, 8'd1, col);
          n++;
        end else if (!is_space(c)) begin
          post_token(KindErr, {56'h0, c}, 8'd1, col);
          n++;
          lx_mode = ModeError;
        end
      end
      lx_col = col;
      lx_fresh = 1'b0;
      if (c == ChNl) begin
        if (lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
        lx_col = '0;
      end
    end
    if (n > 0) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] c);
    if (idle_en && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk_i); while (!s_tready);
    scan_byte(c);
    bytes_sent++;
  endtask

  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_ident(input int len);
    string alnum;
    alnum = {alpha_set, digit_set};
    send_byte(alpha_set[$urandom_range(alpha_set.len() - 1)]);
    for (int i = 1; i < len; i++) send_byte(alnum[$urandom_range(alnum.len() - 1)]);
  endtask

  task automatic send_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_alpha(c) || is_digit(c) || is_space(c) || punct_index(c) >= 0);
    send_byte(c);
  endtask

  // one random text, mostly well-formed tokens, some noise and error bytes
  task automatic send_text();
    int sel;
    int ntok;
    ntok = $urandom_range(1, 12);
    for (int k = 0; k < ntok; k++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        send_ident(($urandom_range(39) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 12));
      end else if (sel < 42) begin
        send_word(kw_names[$urandom_range(9)]);
        if ($urandom_range(9) < 3) send_byte(alpha_set[$urandom_range(alpha_set.len() - 1)]);
      end else if (sel < 58) begin
        repeat ($urandom_range(1, 12)) send_byte(digit_set[$urandom_range(9)]);
      end else if (sel < 78) begin
        send_byte(punct_chars[$urandom_range(punct_chars.len() - 1)]);
      end else if (sel < 82) begin
        send_byte(8'($urandom_range(1, 255)));
      end else if (sel < 85) begin
        send_unknown();
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(space_set[$urandom_range(3)]);
      end
      if ($urandom_range(1) == 1) send_byte(space_set[$urandom_range(3)]);
    end
    if ($urandom_range(9) != 0) send_byte(ChEot);
    texts++;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // receiver: random stalls, a long hold-off on request, quiet stretches
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 11);
    end
  end

  res_t   mon_got;
  token_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      mon_got = res_t'({m_tdata[$bits(res_t)-6:0], m_tuser});
      if (token_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token word, expected none, actual %0h", $time, mon_got);
      end else begin
        mon_want = token_q.pop_front();
        tokens_checked++;
        if (mon_want.r.kind == KindErr) err_tokens++;
        if (mon_want.r.overflow) long_tokens++;
        check_field("kind", 64'(mon_want.r.kind), 64'(mon_got.kind));
        check_field("text", mon_want.r.text, mon_got.text);
        check_field("length", 64'(mon_want.r.length), 64'(mon_got.length));
        check_field("overflow", 64'(mon_want.r.overflow), 64'(mon_got.overflow));
        check_field("line", 64'(mon_want.r.line), 64'(mon_got.line));
        check_field("column", 64'(mon_want.r.column), 64'(mon_got.column));
        check_field("tlast", 64'(mon_want.last), 64'(m_tlast));
      end
    end
  end

  initial begin
    lexer_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      send_byte(DirTab[i].ch);
      if (DirTab[i].typed) token_q[token_q.size()-1].r = DirTab[i].want;
    end

    while (bytes_sent < ItemCount) begin
      if (texts == 3) hold_req = 1'b1;
      if (texts == 6) drain_tokens();
      idle_en  = !(texts >= 9 && texts < 13);
      rx_quiet = !idle_en;
      send_text();
    end
    idle_en  = 1'b1;
    rx_quiet = 1'b0;

    drain_tokens();
    repeat (8) @(posedge clk_i);
    $display("streamed %0d bytes over the directed text and %0d random texts,",
             bytes_sent, texts);
    $display("%0d tokens compared (%0d error, %0d truncated)",
             tokens_checked, err_tokens, long_tokens);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("timeout with %0d token words still expected", token_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
